>>> design/ascii_command_interpreter_macros.svh
// Assertion macros used by the command interpreter top level.
`ifndef ASCII_COMMAND_INTERPRETER_MACROS_SVH
`define ASCII_COMMAND_INTERPRETER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/aci_pkg.sv
// Types, constants and keyword tables of the ASCII command interpreter.
`timescale 1ns / 1ps

package aci_pkg;

   localparam int MaxMsgLen = 1024;
   localparam int PosW      = $clog2(MaxMsgLen + 1);
   localparam int NumKeys   = 6;
   localparam int KeyW      = 7;
   localparam int PeriodW   = 12;
   localparam int DataW     = 32;
   localparam int AddrW     = 3;

   localparam logic [PeriodW-1:0] PeriodLimit = 12'd3600;
   localparam logic [PeriodW-1:0] DigitSat    = 12'd4095;
   localparam logic [PeriodW-1:0] PeriodOne   = 12'd1;

   localparam logic [2:0] CmdOff     = 3'd0;
   localparam logic [2:0] CmdStart   = 3'd1;
   localparam logic [2:0] CmdStop    = 3'd2;
   localparam logic [2:0] CmdPeriod  = 3'd3;
   localparam logic [2:0] CmdScale   = 3'd4;
   localparam logic [2:0] CmdDisp    = 3'd5;
   localparam logic [2:0] CmdUnknown = 3'd6;

   localparam int KeyOff    = 0;
   localparam int KeyStart  = 1;
   localparam int KeyStop   = 2;
   localparam int KeyPeriod = 3;
   localparam int KeyScale  = 4;
   localparam int KeyDisp   = 5;

   localparam logic RegMinPeriod = 1'b0;
   localparam logic RegMaxPeriod = 1'b1;

   localparam logic [7:0] CharNul  = 8'h00;
   localparam logic [7:0] CharZero = "0";
   localparam logic [7:0] CharNine = "9";
   localparam logic [7:0] CharF    = "F";
   localparam logic [7:0] CharC    = "C";
   localparam logic [7:0] CharY    = "Y";
   localparam logic [7:0] CharN    = "N";

   localparam logic [PosW-1:0] PosCharFive  = PosW'(5);
   localparam logic [PosW-1:0] PosCharSix   = PosW'(6);
   localparam logic [PosW-1:0] PosDigits    = PosW'(7);
   localparam logic [PosW-1:0] PosLimit     = PosW'(MaxMsgLen);

   localparam logic [7:0] KeyText [NumKeys][KeyW] = '{
      '{"O", "F", "F", CharNul, CharNul, CharNul, CharNul},
      '{"S", "T", "A", "R", "T", CharNul, CharNul},
      '{"S", "T", "O", "P", CharNul, CharNul, CharNul},
      '{"P", "E", "R", "I", "O", "D", "="},
      '{"S", "C", "A", "L", "E", "=", CharNul},
      '{"D", "I", "S", "P", " ", CharNul, CharNul}
   };

   localparam logic [2:0] KeyLen [NumKeys] = '{3'd3, 3'd5, 3'd4, 3'd7, 3'd6, 3'd5};

   typedef struct packed {
      logic [PosW-1:0]    len;
      logic [NumKeys-1:0] key_hits;
      logic               all_digits;
      logic [PeriodW-1:0] digit_value;
      logic [7:0]         char_five;
      logic [7:0]         char_six;
   } scan_type;

   typedef struct packed {
      logic [2:0]         command;
      logic               invalid;
      logic               power_off;
      logic               sending;
      logic               celsius;
      logic [PeriodW-1:0] report_period;
      logic               display_on;
   } rsp_type;

endpackage

>>> design/aci_msg_scan.sv
// Per-message byte scanner: keyword matching, digit accumulation and length.
`timescale 1ns / 1ps

module aci_msg_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              clear,
   input  logic [7:0]        data_byte,
   output aci_pkg::scan_type scan_next
);
   import aci_pkg::*;

   logic [PosW-1:0]    pos_ff, pos_in;
   logic [NumKeys-1:0] matches_ff, matches_in;
   logic               all_digits_ff, all_digits_in;
   logic [PeriodW-1:0] digit_ff, digit_in;
   logic               ended_ff, ended_in;
   logic [7:0]         char_five_ff, char_five_in;
   logic [7:0]         char_six_ff, char_six_in;
   logic [PeriodW+3:0] digit_wide;
   logic [7:0]         digit_sub;

   assign digit_sub  = data_byte - CharZero;
   assign digit_wide = ({4'b0, digit_ff} << 3) + ({4'b0, digit_ff} << 1)
                       + (PeriodW+4)'(digit_sub[3:0]);

   always_comb begin
      pos_in        = pos_ff;
      matches_in    = matches_ff;
      all_digits_in = all_digits_ff;
      digit_in      = digit_ff;
      ended_in      = ended_ff;
      char_five_in  = char_five_ff;
      char_six_in   = char_six_ff;
      if (step && !ended_ff && (pos_ff < PosLimit)) begin
         if (data_byte == CharNul) begin
            ended_in = 1'b1;
         end else begin
            for (int k = 0; k < NumKeys; k++) begin
               if ((pos_ff < PosW'(KeyLen[k])) && (data_byte != KeyText[k][pos_ff[2:0]])) begin
                  matches_in[k] = 1'b0;
               end
            end
            if (pos_ff >= PosDigits) begin
               if ((data_byte >= CharZero) && (data_byte <= CharNine)) begin
                  if (digit_wide > (PeriodW+4)'(DigitSat)) begin
                     digit_in = DigitSat;
                  end else begin
                     digit_in = digit_wide[PeriodW-1:0];
                  end
               end else begin
                  all_digits_in = 1'b0;
               end
            end
            if (pos_ff == PosCharFive) begin
               char_five_in = data_byte;
            end
            if (pos_ff == PosCharSix) begin
               char_six_in = data_byte;
            end
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pos_ff        <= '0;
         matches_ff    <= '1;
         all_digits_ff <= 1'b1;
         digit_ff      <= '0;
         ended_ff      <= 1'b0;
         char_five_ff  <= '0;
         char_six_ff   <= '0;
      end else if (step) begin
         pos_ff        <= pos_in;
         matches_ff    <= matches_in;
         all_digits_ff <= all_digits_in;
         digit_ff      <= digit_in;
         ended_ff      <= ended_in;
         char_five_ff  <= char_five_in;
         char_six_ff   <= char_six_in;
      end
   end

   assign scan_next.len         = pos_in;
   assign scan_next.key_hits    = matches_in;
   assign scan_next.all_digits  = all_digits_in;
   assign scan_next.digit_value = digit_in;
   assign scan_next.char_five   = char_five_in;
   assign scan_next.char_six    = char_six_in;

endmodule

>>> design/ascii_command_interpreter.sv
// Top level of the ASCII command interpreter with settings, APB registers and result buffer.
`timescale 1ns / 1ps

// The block takes one message byte per cycle while req_stall is low; the result
// of a message is offered at the earliest in the cycle after its last byte is
// taken. Each byte is scanned and, on the last byte, the command is decoded in a
// single pass between the scanner registers and a two-entry result buffer; req_stall
// rises only when the spare entry of that buffer is occupied. After an OFF command
// every further byte is taken and dropped, and no result appears until reset.
`include "ascii_command_interpreter_macros.svh"

module ascii_command_interpreter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_last_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_command,
   output logic                         rsp_invalid,
   output logic                         rsp_power_off,
   output logic                         rsp_sending,
   output logic                         rsp_celsius,
   output logic [aci_pkg::PeriodW-1:0]  rsp_report_period,
   output logic                         rsp_display_on,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [aci_pkg::AddrW-1:0]    paddr,
   input  logic [aci_pkg::DataW-1:0]    pwdata,
   output logic [aci_pkg::DataW-1:0]    prdata,
   output logic                         pready
);
   import aci_pkg::*;

   logic [PeriodW-1:0] min_period_ff, max_period_ff;
   logic               off_ff, off_in;
   logic               send_ff, send_in;
   logic               scale_ff, scale_in;
   logic [PeriodW-1:0] period_ff, period_in;
   logic               disp_ff, disp_in;
   logic               main_valid_ff, skid_valid_ff;
   rsp_type            main_ff, skid_ff;
   rsp_type            result;
   scan_type           scan_next;
   logic               accept, step, push, pop, wr_en, period_ok;
   logic [2:0]         cmd;
   logic               bad;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == RegMaxPeriod) ? DataW'(max_period_ff) : DataW'(min_period_ff);

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign step      = accept && !off_ff;
   assign push      = step && req_last_byte;
   assign pop       = main_valid_ff && !rsp_stall;

   aci_msg_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .clear     (push),
      .data_byte (req_data_byte),
      .scan_next (scan_next)
   );

   assign period_ok = scan_next.all_digits
                      && (scan_next.digit_value >= PeriodOne)
                      && (scan_next.digit_value <= PeriodLimit)
                      && (scan_next.digit_value >= min_period_ff)
                      && (scan_next.digit_value <= max_period_ff);

   always_comb begin
      cmd       = CmdUnknown;
      bad       = 1'b1;
      off_in    = off_ff;
      send_in   = send_ff;
      scale_in  = scale_ff;
      period_in = period_ff;
      disp_in   = disp_ff;
      if (scan_next.key_hits[KeyOff] && (scan_next.len == PosW'(KeyLen[KeyOff]))) begin
         cmd    = CmdOff;
         bad    = 1'b0;
         off_in = 1'b1;
      end else if (scan_next.key_hits[KeyStart]
                   && (scan_next.len == PosW'(KeyLen[KeyStart]))) begin
         cmd     = CmdStart;
         bad     = 1'b0;
         send_in = 1'b1;
      end else if (scan_next.key_hits[KeyStop]
                   && (scan_next.len == PosW'(KeyLen[KeyStop]))) begin
         cmd     = CmdStop;
         bad     = 1'b0;
         send_in = 1'b0;
      end else if (scan_next.key_hits[KeyPeriod]
                   && (scan_next.len >= PosW'(KeyLen[KeyPeriod]))) begin
         cmd = CmdPeriod;
         if (period_ok) begin
            bad       = 1'b0;
            period_in = scan_next.digit_value;
         end
      end else if (scan_next.key_hits[KeyScale]
                   && (scan_next.len >= PosW'(KeyLen[KeyScale]))) begin
         cmd = CmdScale;
         if ((scan_next.len == PosDigits) && (scan_next.char_six == CharF)) begin
            bad      = 1'b0;
            scale_in = 1'b0;
         end else if ((scan_next.len == PosDigits) && (scan_next.char_six == CharC)) begin
            bad      = 1'b0;
            scale_in = 1'b1;
         end
      end else if (scan_next.key_hits[KeyDisp]
                   && (scan_next.len >= PosW'(KeyLen[KeyDisp]))) begin
         cmd = CmdDisp;
         if ((scan_next.len == PosCharSix) && (scan_next.char_five == CharY)) begin
            bad     = 1'b0;
            disp_in = 1'b1;
         end else if ((scan_next.len == PosCharSix) && (scan_next.char_five == CharN)) begin
            bad     = 1'b0;
            disp_in = 1'b0;
         end
      end
   end

   assign result.command       = cmd;
   assign result.invalid       = bad;
   assign result.power_off     = off_in;
   assign result.sending       = send_in;
   assign result.celsius       = scale_in;
   assign result.report_period = period_in;
   assign result.display_on    = disp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= PeriodOne;
         max_period_ff <= PeriodLimit;
      end else if (wr_en) begin
         unique case (paddr[2])
            RegMinPeriod: min_period_ff <= pwdata[PeriodW-1:0];
            RegMaxPeriod: max_period_ff <= pwdata[PeriodW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff    <= 1'b0;
         send_ff   <= 1'b1;
         scale_ff  <= 1'b0;
         period_ff <= 12'd3;
         disp_ff   <= 1'b1;
      end else if (push) begin
         off_ff    <= off_in;
         send_ff   <= send_in;
         scale_ff  <= scale_in;
         period_ff <= period_in;
         disp_ff   <= disp_in;
      end
   end

   // The spare entry fills only while the main entry is held by the receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= push;
         end else begin
            main_valid_ff <= push;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
            skid_ff <= result;
         end else begin
            main_ff <= result;
         end
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid         = main_valid_ff;
   assign rsp_command       = main_ff.command;
   assign rsp_invalid       = main_ff.invalid;
   assign rsp_power_off     = main_ff.power_off;
   assign rsp_sending       = main_ff.sending;
   assign rsp_celsius       = main_ff.celsius;
   assign rsp_report_period = main_ff.report_period;
   assign rsp_display_on    = main_ff.display_on;

   `ACI_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff, "spare entry holds a result while the main entry is empty")
   `ACI_ASSERT_NOW(a_no_result_after_off, clock, reset, off_ff, !push, "result produced after power-off")
   `ACI_ASSERT_NEXT(a_off_sticks, clock, reset, off_ff, off_ff, "power-off flag cleared without reset")
   `ACI_ASSERT_NOW(a_off_cmd_flag, clock, reset, push && (result.command == CmdOff), result.power_off && !result.invalid, "OFF result without power-off flag")
   `ACI_ASSERT_NOW(a_period_nonzero, clock, reset, main_valid_ff, main_ff.report_period != '0, "reported period is zero")

endmodule

>>> tb/ascii_command_interpreter_test.sv
// Self-checking testbench for the ASCII command interpreter: directed and random messages.
`timescale 1ns / 1ps

module ascii_command_interpreter_test;
   import aci_pkg::*;

   typedef struct {
      string       head;
      int          fill_n;
      logic [7:0]  fill_c;
      string       tail;
      bit          typed;
      rsp_type     want;
   } msg_row_t;

   typedef struct {
      bit      typed;
      rsp_type want;
   } msg_tag_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = '0;
   logic                req_last_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_command;
   logic                rsp_invalid;
   logic                rsp_power_off;
   logic                rsp_sending;
   logic                rsp_celsius;
   logic [PeriodW-1:0]  rsp_report_period;
   logic                rsp_display_on;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [AddrW-1:0]    paddr = '0;
   logic [DataW-1:0]    pwdata = '0;
   logic [DataW-1:0]    prdata;
   logic                pready;

   ascii_command_interpreter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_command(rsp_command), .rsp_invalid(rsp_invalid),
      .rsp_power_off(rsp_power_off), .rsp_sending(rsp_sending),
      .rsp_celsius(rsp_celsius), .rsp_report_period(rsp_report_period),
      .rsp_display_on(rsp_display_on),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Settings and per-message scan state of the interpreter as predicted here.
   string       keyword_text [NumKeys] = '{"OFF", "START", "STOP", "PERIOD=", "SCALE=", "DISP "};
   int          lo_limit = 1;
   int          hi_limit = 3600;
   bit          pwr_off = 1'b0;
   bit          send_set = 1'b1;
   bit          cel_set = 1'b0;
   int          period_set = 3;
   bit          disp_set = 1'b1;
   int          scan_pos = 0;
   logic [NumKeys-1:0] key_hits = '1;
   bit          digits_only = 1'b1;
   int          digit_acc = 0;
   bit          str_done = 1'b0;
   logic [7:0]  fifth_ch = '0;
   logic [7:0]  sixth_ch = '0;

   rsp_type     pending_results [$];
   msg_tag_t    msg_tags [$];
   logic [7:0]  msg_bytes [$];
   int          mismatches = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   int phase_lo [7] = '{1, 1, 3600, 100, 2000, 0, 4095};
   int phase_hi [7] = '{3600, 1, 3600, 250, 10, 4095, 4095};

   msg_row_t directed_rows [25] = '{
      '{"", 1, 8'h00, "", 1'b1, '{CmdUnknown, 1'b1, 1'b0, 1'b1, 1'b0, 12'd3, 1'b1}},
      '{"STOP", 0, 8'h00, "", 1'b1, '{CmdStop, 1'b0, 1'b0, 1'b0, 1'b0, 12'd3, 1'b1}},
      '{"START", 0, 8'h00, "", 1'b1, '{CmdStart, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3, 1'b1}},
      '{"PERIOD=3600", 0, 8'h00, "", 1'b1,
        '{CmdPeriod, 1'b0, 1'b0, 1'b1, 1'b0, 12'd3600, 1'b1}},
      '{"PERIOD=1", 0, 8'h00, "", 1'b1, '{CmdPeriod, 1'b0, 1'b0, 1'b1, 1'b0, 12'd1, 1'b1}},
      '{"PERIOD=0", 0, 8'h00, "", 1'b1, '{CmdPeriod, 1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 1'b1}},
      '{"PERIOD=", 0, 8'h00, "", 1'b1, '{CmdPeriod, 1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 1'b1}},
      '{"PERIOD=3601", 0, 8'h00, "", 1'b1,
        '{CmdPeriod, 1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 1'b1}},
      '{"PERIOD=99999", 0, 8'h00, "", 1'b1,
        '{CmdPeriod, 1'b1, 1'b0, 1'b1, 1'b0, 12'd1, 1'b1}},
      '{"PERIOD=12a", 0, 8'h00, "", 1'b0, '0},
      '{"SCALE=C", 0, 8'h00, "", 1'b0, '0},
      '{"SCALE=F", 0, 8'h00, "", 1'b0, '0},
      '{"SCALE=X", 0, 8'h00, "", 1'b0, '0},
      '{"SCALE=CC", 0, 8'h00, "", 1'b0, '0},
      '{"SCALE=", 0, 8'h00, "", 1'b0, '0},
      '{"DISP N", 0, 8'h00, "", 1'b0, '0},
      '{"DISP Y", 0, 8'h00, "", 1'b0, '0},
      '{"DISP ", 0, 8'h00, "", 1'b0, '0},
      '{"DISPY", 0, 8'h00, "", 1'b0, '0},
      '{"STARTX", 0, 8'h00, "", 1'b0, '0},
      '{"STOP", 1, 8'h00, "junk", 1'b0, '0},
      '{"start", 0, 8'h00, "", 1'b0, '0},
      '{"", 1, 8'hFF, "", 1'b0, '0},
      '{"PERIOD=", 1015, "0", "25x", 1'b0, '0},
      '{"DISP N", 20, "Q", "", 1'b0, '0}
   };

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 50) $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   function automatic void interpret_byte(input logic [7:0] c, input logic last,
                                          output bit emit, output rsp_type r);
      logic [2:0] cmd;
      bit         bad;
      int         v;
      emit = 1'b0;
      r = '0;
      if (pwr_off) return;
      if (!str_done && scan_pos < MaxMsgLen) begin
         if (c == CharNul) begin
            str_done = 1'b1;
         end else begin
            for (int k = 0; k < NumKeys; k++) begin
               if (scan_pos < keyword_text[k].len() && c != keyword_text[k][scan_pos])
                  key_hits[k] = 1'b0;
            end
            if (scan_pos >= keyword_text[KeyPeriod].len()) begin
               if (c >= CharZero && c <= CharNine) begin
                  v = digit_acc * 10 + int'(c - CharZero);
                  digit_acc = (v > 4095) ? 4095 : v;
               end else begin
                  digits_only = 1'b0;
               end
            end
            if (scan_pos == 5) fifth_ch = c;
            if (scan_pos == 6) sixth_ch = c;
            scan_pos++;
         end
      end
      if (!last) return;
      cmd = CmdUnknown;
      bad = 1'b1;
      if (key_hits[KeyOff] && scan_pos == keyword_text[KeyOff].len()) begin
         cmd = CmdOff;
         bad = 1'b0;
         pwr_off = 1'b1;
      end else if (key_hits[KeyStart] && scan_pos == keyword_text[KeyStart].len()) begin
         cmd = CmdStart;
         bad = 1'b0;
         send_set = 1'b1;
      end else if (key_hits[KeyStop] && scan_pos == keyword_text[KeyStop].len()) begin
         cmd = CmdStop;
         bad = 1'b0;
         send_set = 1'b0;
      end else if (key_hits[KeyPeriod] && scan_pos >= keyword_text[KeyPeriod].len()) begin
         cmd = CmdPeriod;
         if (digits_only && digit_acc >= 1 && digit_acc <= 3600 &&
             digit_acc >= lo_limit && digit_acc <= hi_limit) begin
            bad = 1'b0;
            period_set = digit_acc;
         end
      end else if (key_hits[KeyScale] && scan_pos >= keyword_text[KeyScale].len()) begin
         cmd = CmdScale;
         if (scan_pos == 7 && sixth_ch == CharF) begin
            bad = 1'b0;
            cel_set = 1'b0;
         end else if (scan_pos == 7 && sixth_ch == CharC) begin
            bad = 1'b0;
            cel_set = 1'b1;
         end
      end else if (key_hits[KeyDisp] && scan_pos >= keyword_text[KeyDisp].len()) begin
         cmd = CmdDisp;
         if (scan_pos == 6 && fifth_ch == CharY) begin
            bad = 1'b0;
            disp_set = 1'b1;
         end else if (scan_pos == 6 && fifth_ch == CharN) begin
            bad = 1'b0;
            disp_set = 1'b0;
         end
      end
      r = '{cmd, bad, pwr_off, send_set, cel_set, PeriodW'(period_set), disp_set};
      emit = 1'b1;
      scan_pos = 0;
      key_hits = '1;
      digits_only = 1'b1;
      digit_acc = 0;
      str_done = 1'b0;
      fifth_ch = '0;
      sixth_ch = '0;
   endfunction

   always @(posedge clock) begin : watch_requests
      bit       emit;
      rsp_type  r;
      msg_tag_t tag;
      if (!reset && req_valid && !req_stall) begin
         interpret_byte(req_data_byte, req_last_byte, emit, r);
         if (emit) begin
            tag = msg_tags.pop_front();
            pending_results.push_back(tag.typed ? tag.want : r);
         end
      end
   end

   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no result pending");
         end else begin
            want = pending_results.pop_front();
            check_field("command", rsp_command, want.command);
            check_field("invalid", rsp_invalid, want.invalid);
            check_field("power_off", rsp_power_off, want.power_off);
            check_field("sending", rsp_sending, want.sending);
            check_field("celsius", rsp_celsius, want.celsius);
            check_field("report_period", rsp_report_period, want.report_period);
            check_field("display_on", rsp_display_on, want.display_on);
         end
      end
   end

   // The result side stalls in modes that are chosen anew whenever a random countdown ends.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic send_byte(logic [7:0] b, logic last);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_message(bit typed, rsp_type want);
      msg_tag_t tag;
      tag.typed = typed;
      tag.want = want;
      msg_tags.push_back(tag);
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   task automatic load_text(string s);
      msg_bytes.delete();
      for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(bit is_write, logic idx, logic [PeriodW-1:0] value);
      logic [DataW-1:0] word;
      word = $urandom;
      word[PeriodW-1:0] = value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= AddrW'(idx) << 2;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (is_write) begin
         if (idx == RegMinPeriod) lo_limit = value;
         else hi_limit = value;
      end else if (prdata != {{(DataW-PeriodW){1'b0}}, value}) begin
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   idx, prdata, value));
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic build_random();
      string text, pad;
      int    kind, v, n, pos, lo_ok, hi_ok;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0: text = "START";
         1: text = "STOP";
         2: text = $urandom_range(0, 1) ? "SCALE=C" : "SCALE=F";
         3: text = $urandom_range(0, 1) ? "DISP Y" : "DISP N";
         default: begin
            lo_ok = (lo_limit > 1) ? lo_limit : 1;
            hi_ok = (hi_limit < 3600) ? hi_limit : 3600;
            case ($urandom_range(0, 7))
               0, 1, 2, 3: v = (lo_ok <= hi_ok) ? $urandom_range(lo_ok, hi_ok)
                                                : $urandom_range(1, 3600);
               4: v = $urandom_range(0, 4095);
               5: v = $urandom_range(0, 999999);
               6: begin
                  case ($urandom_range(0, 6))
                     0: v = 0;
                     1: v = 1;
                     2: v = 3600;
                     3: v = 3601;
                     4: v = lo_limit;
                     5: v = hi_limit;
                     default: v = hi_limit + 1;
                  endcase
               end
               default: v = -1;
            endcase
            pad = ($urandom_range(0, 4) == 0) ? "00" : "";
            text = (v < 0) ? "PERIOD=" : {"PERIOD=", pad, $sformatf("%0d", v)};
         end
      endcase
      load_text(text);
      if (kind >= 72 && kind < 90) begin
         case ($urandom_range(0, 4))
            0: begin
               pos = $urandom_range(0, msg_bytes.size() - 1);
               msg_bytes[pos] = 8'($urandom_range(0, 255));
            end
            1: begin
               n = $urandom_range(1, msg_bytes.size());
               while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
            end
            2: msg_bytes.push_back(8'($urandom_range(32, 126)));
            3: begin
               pos = $urandom_range(0, msg_bytes.size());
               msg_bytes.insert(pos, CharNul);
               msg_bytes.push_back(8'($urandom_range(32, 126)));
            end
            default: begin
               foreach (msg_bytes[i])
                  if (msg_bytes[i] >= "A" && msg_bytes[i] <= "Z") msg_bytes[i] += 8'd32;
            end
         endcase
      end else if (kind >= 90) begin
         msg_bytes.delete();
         n = $urandom_range(1, 12);
         repeat (n)
            msg_bytes.push_back(($urandom_range(0, 7) == 0) ? CharNul
                                                            : 8'($urandom_range(0, 255)));
      end
      // Power-off is kept for the end of the run, so a random message never spells it.
      n = 0;
      while (n < msg_bytes.size() && n < MaxMsgLen && msg_bytes[n] != CharNul) n++;
      if (n == 3 && msg_bytes[0] == "O" && msg_bytes[1] == "F" && msg_bytes[2] == "F")
         msg_bytes[0] = "X";
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         load_text(directed_rows[i].head);
         repeat (directed_rows[i].fill_n) msg_bytes.push_back(directed_rows[i].fill_c);
         for (int j = 0; j < directed_rows[i].tail.len(); j++)
            msg_bytes.push_back(directed_rows[i].tail[j]);
         send_message(directed_rows[i].typed, directed_rows[i].want);
      end
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         csr_access(1'b1, RegMinPeriod, PeriodW'(phase_lo[ph]));
         csr_access(1'b1, RegMaxPeriod, PeriodW'(phase_hi[ph]));
         csr_access(1'b0, RegMinPeriod, PeriodW'(lo_limit));
         csr_access(1'b0, RegMaxPeriod, PeriodW'(hi_limit));
         repeat (6) begin
            build_random();
            send_message(1'b0, '0);
         end
      end
      drain();
      load_text("OFF");
      send_message(1'b0, '0);
      repeat (4) begin
         build_random();
         send_message(1'b0, '0);
      end
      drain();
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
